@@ sv/prefix_filter_insertion_sorter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the prefix filter insertion sorter
// Clocked, reset-qualified property shorthands used by the top level.
// ----------------------------------------------------------------------------
`ifndef PREFIX_FILTER_INSERTION_SORTER_ASSERT_SVH
`define PREFIX_FILTER_INSERTION_SORTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PFIS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PFIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pfis_pkg.sv @@
// ----------------------------------------------------------------------------
// pfis_pkg
// Shared constants and types of the prefix filter insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package pfis_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    localparam int CODE_W  = 24;
    localparam int POP_W   = 20;
    localparam int RANK_W  = 7;
    localparam int TOTAL_W = 26;
    localparam int LEN_W   = 2;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 24;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_PREFIX_LEN   = 2'd0;
    localparam logic [IDX_W-1:0] REG_PREFIX_CHARS = 2'd1;

    // one storage cell: occupancy, code, population
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic [POP_W-1:0]  pop;
    } cell_t;

    // insertion or drain request broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              drain;
        logic [CODE_W-1:0] code;
        logic [POP_W-1:0]  pop;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_LOAD  = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

endpackage

`default_nettype wire

@@ sv/pfis_if.sv @@
// ----------------------------------------------------------------------------
// pfis_rec_if / pfis_res_if
// Valid/ready channels for input records and sorted results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfis_rec_if;
    logic                          valid;
    logic                          ready;
    logic [pfis_pkg::CODE_W-1:0]   area_code;
    logic [pfis_pkg::POP_W-1:0]    population;
    logic                          last_record;

    modport source (output valid, area_code, population, last_record, input ready);
    modport sink   (input valid, area_code, population, last_record, output ready);
endinterface

interface pfis_res_if;
    logic                          valid;
    logic                          ready;
    logic [pfis_pkg::RANK_W-1:0]   rank;
    logic [pfis_pkg::CODE_W-1:0]   out_code;
    logic [pfis_pkg::POP_W-1:0]    out_population;
    logic [pfis_pkg::TOTAL_W-1:0]  running_total;
    logic                          final_result;
    logic                          none_kept;
    logic                          overflowed;

    modport source (output valid, rank, out_code, out_population, running_total,
                    final_result, none_kept, overflowed, input ready);
    modport sink   (input valid, rank, out_code, out_population, running_total,
                    final_result, none_kept, overflowed, output ready);
endinterface

`default_nettype wire

@@ sv/pfis_match.sv @@
// ----------------------------------------------------------------------------
// pfis_match
// Prefix comparator: masks code and prefix by the configured length.
// ----------------------------------------------------------------------------
`default_nettype none

module pfis_match (
    input  wire logic [pfis_pkg::LEN_W-1:0]  prefix_len,
    input  wire logic [pfis_pkg::CODE_W-1:0] prefix_chars,
    input  wire logic [pfis_pkg::CODE_W-1:0] area_code,
    output logic                             match
);

    logic [pfis_pkg::CODE_W-1:0] mask;

    always_comb
    begin
        case (prefix_len)
            2'd0:    mask = 24'h000000;
            2'd1:    mask = 24'hFF0000;
            2'd2:    mask = 24'hFFFF00;
            default: mask = 24'hFFFFFF;
        endcase
        match = ((area_code ^ prefix_chars) & mask) == '0;
    end

endmodule

`default_nettype wire

@@ sv/pfis_cell.sv @@
// ----------------------------------------------------------------------------
// pfis_cell
// One slot of the sorted chain: hold, take the new word, shift up or down.
// ----------------------------------------------------------------------------
`default_nettype none

module pfis_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pfis_pkg::cell_ctrl_t ctrl,
    input  wire pfis_pkg::cell_t     prev_data,
    input  wire logic                prev_gt,
    input  wire pfis_pkg::cell_t     next_data,
    output pfis_pkg::cell_t          data,
    output logic                     gt
);

    logic                          valid_reg, valid_next;
    logic [pfis_pkg::CODE_W-1:0]   code_reg, code_next;
    logic [pfis_pkg::POP_W-1:0]    pop_reg, pop_next;

    // empty slots count as larger, so the new word lands after equals
    assign gt = !valid_reg || (pop_reg > ctrl.pop);

    always_comb
    begin
        valid_next = valid_reg;
        code_next  = code_reg;
        pop_next   = pop_reg;
        if (ctrl.drain)
        begin
            valid_next = next_data.valid;
            code_next  = next_data.code;
            pop_next   = next_data.pop;
        end
        else if (ctrl.ins && gt)
        begin
            if (prev_gt)
            begin
                valid_next = prev_data.valid;
                code_next  = prev_data.code;
                pop_next   = prev_data.pop;
            end
            else
            begin
                valid_next = 1'b1;
                code_next  = ctrl.code;
                pop_next   = ctrl.pop;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        pop_reg  <= pop_next;
    end

    assign data = '{valid: valid_reg, code: code_reg, pop: pop_reg};

endmodule

`default_nettype wire

@@ sv/prefix_filter_insertion_sorter.sv @@
// ----------------------------------------------------------------------------
// prefix_filter_insertion_sorter
// Filters area records by prefix and sorts them stably by population.
//
// Usage:
//   records : input words (area_code, population, last_record), valid/ready.
//   results : output words in rank order with a running population total.
//   cfg_*   : write port for prefix_len (index 0) and prefix_chars (index 1);
//             write only while idle.
//   A word is taken each cycle while loading: all cells compare the new
//   population at once and the chain shifts in one step. The word marked
//   last_record is inserted like any other; records then stays not ready
//   while the chain drains from its head, one result per cycle the receiver
//   takes, the first via the state and output registers. N kept words
//   give N results, an empty run one flagged result. Words kept beyond
//   MAX_RECORDS are dropped and flag every result. Reset empties the chain
//   (valid bits only), clears the counters, output valid and the config
//   registers. When results stalls, the output register holds its word and
//   the drain pauses; a new run loads once the final result is registered.
// ----------------------------------------------------------------------------
`default_nettype none
`include "prefix_filter_insertion_sorter_assert.svh"

module prefix_filter_insertion_sorter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    pfis_rec_if.sink                           records,
    pfis_res_if.source                         results,
    input  wire logic                          cfg_we,
    input  wire logic [pfis_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [pfis_pkg::DATA_W-1:0]   cfg_data
);

    localparam int N = pfis_pkg::MAX_RECORDS;

    // configuration
    logic [pfis_pkg::LEN_W-1:0]    prefix_len_reg;
    logic [pfis_pkg::CODE_W-1:0]   prefix_chars_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_len_reg   <= '0;
            prefix_chars_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfis_pkg::REG_PREFIX_LEN:
                    prefix_len_reg <= cfg_data[pfis_pkg::LEN_W-1:0];
                pfis_pkg::REG_PREFIX_CHARS:
                    prefix_chars_reg <= cfg_data[pfis_pkg::CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    pfis_pkg::state_t              state_reg, state_next;
    logic [pfis_pkg::CNT_W-1:0]    kept_reg, kept_next;
    logic                          dropped_reg, dropped_next;
    logic [pfis_pkg::CNT_W-1:0]    emit_reg, emit_next;
    logic [pfis_pkg::TOTAL_W-1:0]  total_reg, total_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [pfis_pkg::RANK_W-1:0]   rank_reg, rank_next;
    logic [pfis_pkg::CODE_W-1:0]   ocode_reg, ocode_next;
    logic [pfis_pkg::POP_W-1:0]    opop_reg, opop_next;
    logic [pfis_pkg::TOTAL_W-1:0]  otot_reg, otot_next;
    logic                          ofinal_reg, ofinal_next;
    logic                          onone_reg, onone_next;
    logic                          oovf_reg, oovf_next;

    logic                          match;
    logic                          in_acc;
    logic                          load;
    logic                          full;
    logic [pfis_pkg::CNT_W-1:0]    emit_inc;
    pfis_pkg::cell_ctrl_t          ctrl;
    pfis_pkg::cell_t               cell_q [N];
    logic                          cell_gt [N];

    pfis_match u_match (
        .prefix_len   (prefix_len_reg),
        .prefix_chars (prefix_chars_reg),
        .area_code    (records.area_code),
        .match        (match)
    );

    assign records.ready = (state_reg == pfis_pkg::S_LOAD);
    assign in_acc        = records.valid && records.ready;
    assign full          = (kept_reg == pfis_pkg::CNT_W'(N));
    // advance the drain whenever the output register is free or being taken
    assign load          = (state_reg == pfis_pkg::S_DRAIN) && (!out_valid_reg || results.ready);
    assign emit_inc      = emit_reg + 1'b1;

    assign ctrl.ins   = in_acc && match && !full;
    assign ctrl.drain = load && (kept_reg != '0);
    assign ctrl.code  = records.area_code;
    assign ctrl.pop   = records.population;

    // the chain: head at cell 0, smallest population first
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        pfis_pkg::cell_t prev_d;
        pfis_pkg::cell_t next_d;
        logic            prev_g;

        if (i == 0)
        begin : g_head
            assign prev_d = '0;
            assign prev_g = 1'b0;
        end
        else
        begin : g_body
            assign prev_d = cell_q[i-1];
            assign prev_g = cell_gt[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign next_d = '0;
        end
        else
        begin : g_mid
            assign next_d = cell_q[i+1];
        end

        pfis_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .prev_data (prev_d),
            .prev_gt   (prev_g),
            .next_data (next_d),
            .data      (cell_q[i]),
            .gt        (cell_gt[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        kept_next      = kept_reg;
        dropped_next   = dropped_reg;
        emit_next      = emit_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !results.ready;
        rank_next      = rank_reg;
        ocode_next     = ocode_reg;
        opop_next      = opop_reg;
        otot_next      = otot_reg;
        ofinal_next    = ofinal_reg;
        onone_next     = onone_reg;
        oovf_next      = oovf_reg;

        case (state_reg)
            pfis_pkg::S_LOAD:
            begin
                if (ctrl.ins)
                    kept_next = kept_reg + 1'b1;
                if (in_acc && match && full)
                    dropped_next = 1'b1;
                if (in_acc && records.last_record)
                    state_next = pfis_pkg::S_DRAIN;
            end
            pfis_pkg::S_DRAIN:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (kept_reg == '0)
                    begin
                        // empty run: one flagged word
                        rank_next    = '0;
                        ocode_next   = '0;
                        opop_next    = '0;
                        otot_next    = '0;
                        ofinal_next  = 1'b1;
                        onone_next   = 1'b1;
                        oovf_next    = 1'b0;
                        dropped_next = 1'b0;
                        state_next   = pfis_pkg::S_LOAD;
                    end
                    else
                    begin
                        total_next  = total_reg + pfis_pkg::TOTAL_W'(cell_q[0].pop);
                        rank_next   = pfis_pkg::RANK_W'(emit_inc);
                        ocode_next  = cell_q[0].code;
                        opop_next   = cell_q[0].pop;
                        otot_next   = total_next;
                        ofinal_next = (emit_inc == kept_reg);
                        onone_next  = 1'b0;
                        oovf_next   = dropped_reg;
                        emit_next   = emit_inc;
                        if (emit_inc == kept_reg)
                        begin
                            // run done: drop counters back to idle
                            kept_next    = '0;
                            dropped_next = 1'b0;
                            emit_next    = '0;
                            total_next   = '0;
                            state_next   = pfis_pkg::S_LOAD;
                        end
                    end
                end
            end
            default:
                state_next = pfis_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfis_pkg::S_LOAD;
            kept_reg      <= '0;
            dropped_reg   <= 1'b0;
            emit_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kept_reg      <= kept_next;
            dropped_reg   <= dropped_next;
            emit_reg      <= emit_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg   <= rank_next;
        ocode_reg  <= ocode_next;
        opop_reg   <= opop_next;
        otot_reg   <= otot_next;
        ofinal_reg <= ofinal_next;
        onone_reg  <= onone_next;
        oovf_reg   <= oovf_next;
    end

    assign results.valid          = out_valid_reg;
    assign results.rank           = rank_reg;
    assign results.out_code       = ocode_reg;
    assign results.out_population = opop_reg;
    assign results.running_total  = otot_reg;
    assign results.final_result   = ofinal_reg;
    assign results.none_kept      = onone_reg;
    assign results.overflowed     = oovf_reg;

    // checks
    `PFIS_ASSERT_IMPL(a_kept_bound, 1'b1, kept_reg <= pfis_pkg::CNT_W'(N),
        "kept count above capacity")
    `PFIS_ASSERT_IMPL(a_drop_full, dropped_reg, full,
        "drop flag set while chain not full")
    `PFIS_ASSERT_IMPL(a_head_valid, ctrl.drain, cell_q[0].valid,
        "draining an empty chain head")
    `PFIS_ASSERT_NEXT(a_final_idle, load && ofinal_next, state_reg == pfis_pkg::S_LOAD,
        "final word loaded but drain did not end")

endmodule

`default_nettype wire
